// ===== src/fcrl_pkg.sv =====
package fcrl_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] FRAME_LAST_BEAT = 3'd6;
    localparam logic [2:0] RX_LAST_INDEX   = 3'd6;

    // input item kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // result kinds
    localparam logic RES_TX   = 1'b0;
    localparam logic RES_DONE = 1'b1;

    // finish status
    localparam logic ST_GOOD   = 1'b0;
    localparam logic ST_FAILED = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_SYNC  = 2'd0;
    localparam logic [1:0] REG_FIRST = 2'd1;
    localparam logic [1:0] REG_RETRY = 2'd2;
    localparam logic [1:0] REG_TRIES = 2'd3;

    localparam logic [7:0] SYNC_RESET  = 8'd117;
    localparam logic [7:0] FIRST_RESET = 8'd10;
    localparam logic [7:0] RETRY_RESET = 8'd4;
    localparam logic [3:0] TRIES_RESET = 4'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_FIRST,
        PH_WAIT_SECOND
    } t_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] command;
        logic [7:0] arg_one;
        logic [7:0] arg_two;
        logic [7:0] arg_three;
        logic [7:0] arg_four;
        logic       skip_first_reply;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic       status;
        logic [7:0] reply_result;
        logic [7:0] reply_data_one;
        logic [7:0] reply_data_two;
        logic [7:0] reply_data_three;
    } t_out_item;

    typedef struct packed {
        logic [7:0] sync_byte;
        logic [7:0] first_wait_ticks;
        logic [7:0] retry_wait_ticks;
        logic [3:0] max_tries;
    } t_cfg;

    // one queued job: a whole frame to send, or a finish beat
    typedef struct packed {
        logic        result_kind;
        logic        status;
        logic [7:0]  sync_byte;
        logic [39:0] body;
        logic [7:0]  checksum;
        logic [31:0] reply;
    } t_job;

endpackage

// ===== src/fcrl_queue.sv =====
module fcrl_queue #(
    parameter int DEPTH = fcrl_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fcrl_pkg::t_job i_entry,
    input  logic          i_pop,
    output fcrl_pkg::t_job o_head,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fcrl_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== src/fcrl_front.sv =====
module fcrl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fcrl_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    input  fcrl_pkg::t_in_item i_item,
    input  logic              i_queue_full,
    output logic              o_stall,
    output logic              o_push,
    output fcrl_pkg::t_job     o_job
);

    fcrl_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_wait_left, n_wait_left;
    logic [3:0]  r_tries_left, n_tries_left;
    logic [2:0]  r_rx_count, n_rx_count;
    logic [7:0]  r_rx_sum;
    logic [7:0]  r_rx_body [5];
    logic [39:0] r_body;
    logic [7:0]  r_tx_sum;
    logic        r_mode;

    logic        accept, active;
    logic        ev_start, ev_byte, ev_tick;
    logic        byte_take, frame_end, skip, good, timeout, lose, give_up, retry;
    logic [39:0] new_body;
    logic [7:0]  new_sum;
    logic [7:0]  rx_b;

    assign o_stall = i_queue_full;
    assign accept  = i_valid && !i_queue_full;
    assign active  = (r_phase != fcrl_pkg::PH_IDLE);
    assign rx_b    = i_item.rx_byte;

    assign new_body = {i_item.arg_four, i_item.arg_three, i_item.arg_two,
                       i_item.arg_one, i_item.command};
    assign new_sum  = i_item.command + i_item.arg_one + i_item.arg_two
                    + i_item.arg_three + i_item.arg_four;

    // event decode
    always_comb begin
        ev_start  = accept && (i_item.kind == fcrl_pkg::KIND_START);
        ev_byte   = accept && active && (i_item.kind == fcrl_pkg::KIND_BYTE);
        ev_tick   = accept && active && (i_item.kind == fcrl_pkg::KIND_TICK);
        byte_take = ev_byte && ((r_rx_count != 3'd0) || (rx_b == i_cfg.sync_byte));
        frame_end = byte_take && (r_rx_count == fcrl_pkg::RX_LAST_INDEX);
        skip      = frame_end && (r_phase == fcrl_pkg::PH_WAIT_FIRST) && r_mode;
        good      = frame_end && !skip && (r_rx_sum == rx_b) && (r_rx_body[0] == 8'd0);
        timeout   = ev_tick && (r_wait_left <= 8'd1);
        lose      = (frame_end && !skip && !good) || timeout;
        give_up   = lose && (r_tries_left <= 4'd1);
        retry     = lose && !give_up;
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        if (ev_start || retry) begin
            n_phase = fcrl_pkg::PH_WAIT_FIRST;
        end else if (skip) begin
            n_phase = fcrl_pkg::PH_WAIT_SECOND;
        end else if (good || give_up) begin
            n_phase = fcrl_pkg::PH_IDLE;
        end
    end

    // counters and queue push
    always_comb begin
        n_wait_left  = r_wait_left;
        n_tries_left = r_tries_left;
        n_rx_count   = r_rx_count;
        if (ev_start || skip) begin
            n_wait_left = i_cfg.first_wait_ticks;
        end else if (good || give_up) begin
            n_wait_left = 8'd0;
        end else if (retry) begin
            n_wait_left = i_cfg.retry_wait_ticks;
        end else if (ev_tick) begin
            n_wait_left = r_wait_left - 8'd1;
        end

        if (ev_start) begin
            n_tries_left = i_cfg.max_tries;
        end else if (give_up) begin
            n_tries_left = 4'd0;
        end else if (retry) begin
            n_tries_left = r_tries_left - 4'd1;
        end

        if (ev_start || frame_end) begin
            n_rx_count = 3'd0;
        end else if (byte_take) begin
            n_rx_count = r_rx_count + 3'd1;
        end

        o_push            = ev_start || retry || good || give_up;
        o_job.result_kind = (good || give_up) ? fcrl_pkg::RES_DONE : fcrl_pkg::RES_TX;
        o_job.status      = give_up ? fcrl_pkg::ST_FAILED : fcrl_pkg::ST_GOOD;
        o_job.sync_byte   = i_cfg.sync_byte;
        o_job.body        = ev_start ? new_body : r_body;
        o_job.checksum    = ev_start ? new_sum : r_tx_sum;
        o_job.reply       = good ? {r_rx_body[1], r_rx_body[2], r_rx_body[3], r_rx_body[4]}
                                 : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= fcrl_pkg::PH_IDLE;
            r_wait_left  <= 8'd0;
            r_tries_left <= 4'd0;
            r_rx_count   <= 3'd0;
        end else begin
            r_phase      <= n_phase;
            r_wait_left  <= n_wait_left;
            r_tries_left <= n_tries_left;
            r_rx_count   <= n_rx_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ev_start) begin
            r_body   <= new_body;
            r_tx_sum <= new_sum;
            r_mode   <= i_item.skip_first_reply;
        end
        if (byte_take) begin
            if (r_rx_count == 3'd0) begin
                r_rx_sum <= 8'd0;
            end else if (r_rx_count != fcrl_pkg::RX_LAST_INDEX) begin
                r_rx_sum <= r_rx_sum + rx_b;
            end
        end
        for (int j = 0; j < 5; j++) begin
            if (byte_take && (r_rx_count == 3'(j + 1))) begin
                r_rx_body[j] <= rx_b;
            end
        end
    end

endmodule

// ===== src/fcrl_back.sv =====
module fcrl_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fcrl_pkg::t_job      i_head,
    input  logic               i_empty,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output fcrl_pkg::t_out_item o_item
);

    logic [2:0]          r_beat, n_beat;
    logic                r_valid;
    fcrl_pkg::t_out_item r_item, n_item;
    logic                load;
    logic [7:0]          frame_byte;

    assign load    = !i_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        case (r_beat)
            3'd0:    frame_byte = i_head.sync_byte;
            3'd1:    frame_byte = i_head.body[7:0];
            3'd2:    frame_byte = i_head.body[15:8];
            3'd3:    frame_byte = i_head.body[23:16];
            3'd4:    frame_byte = i_head.body[31:24];
            3'd5:    frame_byte = i_head.body[39:32];
            default: frame_byte = i_head.checksum;
        endcase
    end

    always_comb begin
        n_beat = r_beat;
        o_pop  = 1'b0;
        n_item = '0;
        n_item.result_kind = i_head.result_kind;
        if (i_head.result_kind == fcrl_pkg::RES_DONE) begin
            n_item.status           = i_head.status;
            n_item.reply_result     = i_head.reply[31:24];
            n_item.reply_data_one   = i_head.reply[23:16];
            n_item.reply_data_two   = i_head.reply[15:8];
            n_item.reply_data_three = i_head.reply[7:0];
            o_pop = load;
        end else begin
            n_item.tx_byte = frame_byte;
            n_item.tx_last = (r_beat == fcrl_pkg::FRAME_LAST_BEAT);
            if (load) begin
                if (r_beat == fcrl_pkg::FRAME_LAST_BEAT) begin
                    n_beat = 3'd0;
                    o_pop  = 1'b1;
                end else begin
                    n_beat = r_beat + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat  <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            r_beat <= n_beat;
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== src/framed_command_retry_link.sv =====
// Channel   Dir  Handshake                  Payload
// in        in   i_in_valid / o_in_stall    i_in_data  (fcrl_pkg::t_in_item)
// out       out  o_out_valid / i_out_stall  o_out_data (fcrl_pkg::t_out_item)
// config    in   APB psel/penable/pwrite    paddr[3:0], pwdata, prdata
//
// Flow: every input beat is taken while the job queue has room; a start or
//   retry then needs seven output beats for its frame, a finish one. Output
//   is one beat per cycle unless stalled, set by the single output register.
// Reset: synchronous, active low; clears phase, counters, queue and output
//   valid, and loads the configuration defaults.
// Stalls: the front stalls only on a full job queue; the back holds a valid
//   output beat while i_out_stall is high.
module framed_command_retry_link #(
    parameter int QUEUE_DEPTH = fcrl_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fcrl_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fcrl_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    fcrl_pkg::t_cfg r_cfg;
    fcrl_pkg::t_job push_job, head_job;
    logic           push, pop, q_full, q_empty;
    logic           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Write the register at the access cycle; byte lanes beyond its width drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_byte        <= fcrl_pkg::SYNC_RESET;
            r_cfg.first_wait_ticks <= fcrl_pkg::FIRST_RESET;
            r_cfg.retry_wait_ticks <= fcrl_pkg::RETRY_RESET;
            r_cfg.max_tries        <= fcrl_pkg::TRIES_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                fcrl_pkg::REG_SYNC:  r_cfg.sync_byte        <= pwdata[7:0];
                fcrl_pkg::REG_FIRST: r_cfg.first_wait_ticks <= pwdata[7:0];
                fcrl_pkg::REG_RETRY: r_cfg.retry_wait_ticks <= pwdata[7:0];
                fcrl_pkg::REG_TRIES: r_cfg.max_tries        <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Read back is combinational; every address in range maps to a register.
    always_comb begin
        unique case (paddr[3:2])
            fcrl_pkg::REG_SYNC:  prdata = {24'd0, r_cfg.sync_byte};
            fcrl_pkg::REG_FIRST: prdata = {24'd0, r_cfg.first_wait_ticks};
            fcrl_pkg::REG_RETRY: prdata = {24'd0, r_cfg.retry_wait_ticks};
            fcrl_pkg::REG_TRIES: prdata = {28'd0, r_cfg.max_tries};
            default:             prdata = 32'd0;
        endcase
    end

    // Front: framer, wait and try counters; turns each beat into at most one job.
    fcrl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_in_valid),
        .i_item       (i_in_data),
        .i_queue_full (q_full),
        .o_stall      (o_in_stall),
        .o_push       (push),
        .o_job        (push_job)
    );

    // Job queue: decouples command bookkeeping from the byte-serial output.
    fcrl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: expand frame jobs into seven beats, finish jobs into one.
    fcrl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_job),
        .i_empty (q_empty),
        .o_pop   (pop),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_item  (o_out_data)
    );

endmodule

// ===== src/fcrl_checker.sv =====
module fcrl_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input fcrl_pkg::t_out_item o_out_data
);

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    // reset drops any pending beat
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // finish beats carry no frame byte
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.result_kind == fcrl_pkg::RES_DONE)
        |-> (o_out_data.tx_byte == 8'd0) && !o_out_data.tx_last)
        else $error("finish beat carries frame byte");

    // failed finish and transmit beats carry no reply bytes
    a_no_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_data.result_kind == fcrl_pkg::RES_TX)
                        || (o_out_data.status == fcrl_pkg::ST_FAILED))
        |-> (o_out_data.reply_result == 8'd0) && (o_out_data.reply_data_one == 8'd0)
            && (o_out_data.reply_data_two == 8'd0) && (o_out_data.reply_data_three == 8'd0))
        else $error("reply bytes on a beat without a good reply");

endmodule

bind framed_command_retry_link fcrl_checker u_fcrl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
